### rtl/core/pss_pkg.sv
// Shared types, constants and helper functions of the packet snoop signal aspect block.
package pss_pkg;

  // Packet store geometry.
  localparam int PACKET_BYTES  = 32;
  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_W        = $clog2(PACKET_BYTES);
  localparam int COUNT_W       = $clog2(PACKET_BYTES + 1);
  localparam int INDEX_W       = 5;
  localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
  localparam int TABLE_W       = TABLE_ENTRIES * 8;

  // Header byte positions.
  localparam logic [INDEX_W-1:0] DEST_INDEX   = 5'd0;
  localparam logic [INDEX_W-1:0] SOURCE_INDEX = 5'd1;
  localparam logic [INDEX_W-1:0] TYPE_INDEX   = 5'd5;

  // Addresses and command types.
  localparam logic [7:0] BROADCAST_ADDR       = 8'hFF;
  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h03;
  localparam logic [7:0] CMD_ADDRESS  = 8'h41;
  localparam logic [7:0] CMD_WRITE    = 8'h57;
  localparam logic [7:0] CMD_READ     = 8'h52;
  localparam logic [7:0] CMD_VERSION  = 8'h56;
  localparam logic [7:0] CMD_RESET    = 8'h58;

  // Flag bits within a signal nibble.
  localparam int FLAG_OCC  = 0;
  localparam int FLAG_ADV  = 1;
  localparam int FLAG_ADV2 = 2;
  localparam int FLAG_TMBL = 3;

  // Aspect codes.
  localparam logic [2:0] LAMP_GREEN      = 3'd1;
  localparam logic [2:0] LAMP_YELLOW     = 3'd2;
  localparam logic [2:0] LAMP_FLASH_YLW  = 3'd3;
  localparam logic [2:0] LAMP_RED        = 3'd4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS = 3'd0,
    REG_SOURCE_LOW     = 3'd1,
    REG_SOURCE_HIGH    = 3'd2,
    REG_TYPE_LOW       = 3'd3,
    REG_TYPE_HIGH      = 3'd4,
    REG_SELECT_LOW     = 3'd5,
    REG_SELECT_HIGH    = 3'd6
  } reg_idx_e;

  // Configuration seen by the match unit and the sequencer.
  typedef struct packed {
    logic [7:0]         device_address;
    logic [TABLE_W-1:0] src_tab;
    logic [TABLE_W-1:0] typ_tab;
    logic [TABLE_W-1:0] sel_tab;
  } cfg_t;

  // Control of the packet store.
  typedef struct packed {
    logic       wr_en;
    logic       clear;
    logic [7:0] wr_data;
  } store_ctrl_t;

  // Aspect of one signal from its flag nibble.
  function automatic logic [2:0] aspect_of(input logic [3:0] nib);
    logic [2:0] asp;
    if (nib[FLAG_OCC] || nib[FLAG_TMBL]) begin
      asp = LAMP_RED;
    end else if (nib[FLAG_ADV]) begin
      asp = LAMP_YELLOW;
    end else if (nib[FLAG_ADV2]) begin
      asp = LAMP_FLASH_YLW;
    end else begin
      asp = LAMP_GREEN;
    end
    return asp;
  endfunction

endpackage

### rtl/core/packet_snoop_signal_aspect.sv
// Top level of the packet snoop signal aspect block: sequencer, registers and output stage.
//
// Packet bytes arrive one item at a time; a byte that is not final is taken and the block
// stays ready. The final byte starts a pass of three header reads, one filter step,
// sixteen table steps through the single read port of the packet store and the one shared
// match unit, one entry per cycle, and the output load. A dropped packet skips the table
// steps. The input is ready again in the cycle after the load, so the next item is taken
// only once the pass is through, later while an earlier result still waits downstream.
// The store needs no clearing pass: its fill count makes bytes that were not received
// read as zero.
module packet_snoop_signal_aspect (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // crc_good
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] aspect_one, [5:3] aspect_two, [8:6] aspect_three, [11:9] aspect_four,
  // [27:12] occupancy_flags, [31:28] zero
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser    // packet_accepted
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DST,
    S_SRC,
    S_TYP,
    S_FILT,
    S_ENT,
    S_OUT
  } state_e;

  state_e                      state_q;
  pss_pkg::cfg_t               cfg_q;
  pss_pkg::store_ctrl_t        store_ctrl;
  logic [pss_pkg::INDEX_W-1:0] rd_idx;
  logic [7:0]                  rd_byte;
  logic [7:0]                  dst_q;
  logic [7:0]                  src_q;
  logic [7:0]                  typ_q;
  logic                        crc_q;
  logic                        acc_q;
  logic [pss_pkg::ENTRY_W-1:0] ent_q;
  logic [2:0]                  bitn_q;
  logic [15:0]                 occ_q;
  logic [15:0]                 occ_next;
  logic [pss_pkg::ENTRY_W-1:0] issue_ent;
  logic [7:0]                  issue_sel;
  logic                        in_acc;
  logic                        drop;
  logic                        out_free;
  logic                        out_valid_q;
  logic [31:0]                 out_data_q;
  logic                        out_acc_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_acc_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address <= pss_pkg::DEVICE_ADDRESS_RESET;
      cfg_q.src_tab        <= '0;
      cfg_q.typ_tab        <= '0;
      cfg_q.sel_tab        <= '0;
    end else if (cfg_we_i) begin
      unique case (pss_pkg::reg_idx_e'(cfg_index_i))
        pss_pkg::REG_DEVICE_ADDRESS: cfg_q.device_address      <= cfg_data_i[7:0];
        pss_pkg::REG_SOURCE_LOW:     cfg_q.src_tab[63:0]       <= cfg_data_i;
        pss_pkg::REG_SOURCE_HIGH:    cfg_q.src_tab[127:64]     <= cfg_data_i;
        pss_pkg::REG_TYPE_LOW:       cfg_q.typ_tab[63:0]       <= cfg_data_i;
        pss_pkg::REG_TYPE_HIGH:      cfg_q.typ_tab[127:64]     <= cfg_data_i;
        pss_pkg::REG_SELECT_LOW:     cfg_q.sel_tab[63:0]       <= cfg_data_i;
        pss_pkg::REG_SELECT_HIGH:    cfg_q.sel_tab[127:64]     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Store control: write each item, empty the store once the result is loaded.
  assign store_ctrl.wr_en   = in_acc;
  assign store_ctrl.wr_data = s_axis_tdata;
  assign store_ctrl.clear   = (state_q == S_OUT) && out_free;

  // Read address: header bytes first, then the selected byte of each entry in turn.
  assign issue_ent = (state_q == S_FILT) ? '0 : ent_q + 1'b1;
  assign issue_sel = cfg_q.sel_tab[{issue_ent, 3'b000} +: 8];

  always_comb begin
    unique case (state_q)
      S_DST:   rd_idx = pss_pkg::DEST_INDEX;
      S_SRC:   rd_idx = pss_pkg::SOURCE_INDEX;
      S_TYP:   rd_idx = pss_pkg::TYPE_INDEX;
      default: rd_idx = issue_sel[pss_pkg::INDEX_W-1:0];
    endcase
  end

  pss_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (store_ctrl),
    .rd_idx_i  (rd_idx),
    .rd_byte_o (rd_byte)
  );

  pss_match u_match (
    .cfg_i  (cfg_q),
    .ent_i  (ent_q),
    .src_i  (src_q),
    .typ_i  (typ_q),
    .byte_i (rd_byte),
    .bitn_i (bitn_q),
    .occ_i  (occ_q),
    .occ_o  (occ_next)
  );

  // Filters; the type byte arrives from the store in the filter cycle.
  assign drop = (src_q == cfg_q.device_address) ||
                ((dst_q != pss_pkg::BROADCAST_ADDR) && (dst_q != cfg_q.device_address)) ||
                !crc_q ||
                (rd_byte == pss_pkg::CMD_ADDRESS) || (rd_byte == pss_pkg::CMD_WRITE) ||
                (rd_byte == pss_pkg::CMD_READ) || (rd_byte == pss_pkg::CMD_VERSION) ||
                (rd_byte == pss_pkg::CMD_RESET);

  // Sequencer with its working and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_acc_q   <= 1'b0;
      ent_q       <= '0;
      bitn_q      <= '0;
      dst_q       <= '0;
      src_q       <= '0;
      typ_q       <= '0;
      acc_q       <= 1'b0;
      crc_q       <= 1'b0;
    end else begin
      // The output register fills when a result is loaded and empties when taken.
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tlast) begin
            crc_q   <= s_axis_tuser;
            state_q <= S_DST;
          end
        end
        S_DST: begin
          state_q <= S_SRC;
        end
        S_SRC: begin
          dst_q   <= rd_byte;
          state_q <= S_TYP;
        end
        S_TYP: begin
          src_q   <= rd_byte;
          state_q <= S_FILT;
        end
        S_FILT: begin
          typ_q   <= rd_byte;
          acc_q   <= !drop;
          ent_q   <= '0;
          bitn_q  <= issue_sel[7:5];
          state_q <= drop ? S_OUT : S_ENT;
        end
        S_ENT: begin
          occ_q  <= occ_next;
          ent_q  <= issue_ent;
          bitn_q <= issue_sel[7:5];
          if (ent_q == pss_pkg::ENTRY_W'(pss_pkg::TABLE_ENTRIES - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_acc_q   <= acc_q;
            out_data_q  <= {4'b0000, occ_q,
                            pss_pkg::aspect_of(occ_q[15:12]),
                            pss_pkg::aspect_of(occ_q[11:8]),
                            pss_pkg::aspect_of(occ_q[7:4]),
                            pss_pkg::aspect_of(occ_q[3:0])};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/pss_store.sv
// Packet byte store with a fill count and one registered read port.
module pss_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pss_pkg::store_ctrl_t         ctrl_i,
  input  logic [pss_pkg::INDEX_W-1:0]  rd_idx_i,
  output logic [7:0]                   rd_byte_o
);

  logic [7:0]                  mem_q [pss_pkg::PACKET_BYTES];
  logic [pss_pkg::COUNT_W-1:0] count_q;
  logic [7:0]                  rd_data_q;
  logic                        rd_ok_q;
  logic [pss_pkg::INDEX_W:0]   idx_ext;
  logic [pss_pkg::INDEX_W:0]   cnt_ext;
  logic                        rd_ok;

  // An entry holds data only below the fill count; anything else reads as zero.
  assign idx_ext = {1'b0, rd_idx_i};
  assign cnt_ext = (pss_pkg::INDEX_W + 1)'(count_q);
  assign rd_ok   = (idx_ext < (pss_pkg::INDEX_W + 1)'(pss_pkg::PACKET_BYTES)) &&
                   (idx_ext < cnt_ext);

  // Fill count: saturates at the store depth and returns to zero after a packet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      rd_ok_q <= rd_ok;
      if (ctrl_i.clear) begin
        count_q <= '0;
      end else if (ctrl_i.wr_en &&
                   (count_q < pss_pkg::COUNT_W'(pss_pkg::PACKET_BYTES))) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Byte memory: one write and one read a cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && (count_q < pss_pkg::COUNT_W'(pss_pkg::PACKET_BYTES))) begin
      mem_q[count_q[pss_pkg::ADDR_W-1:0]] <= ctrl_i.wr_data;
    end
    rd_data_q <= mem_q[rd_idx_i[pss_pkg::ADDR_W-1:0]];
  end

  assign rd_byte_o = rd_ok_q ? rd_data_q : 8'h00;

endmodule

### rtl/core/pss_match.sv
// Shared table match unit: compares one entry and updates its occupancy flag.
module pss_match (
  input  pss_pkg::cfg_t                cfg_i,
  input  logic [pss_pkg::ENTRY_W-1:0]  ent_i,
  input  logic [7:0]                   src_i,
  input  logic [7:0]                   typ_i,
  input  logic [7:0]                   byte_i,
  input  logic [2:0]                   bitn_i,
  input  logic [15:0]                  occ_i,
  output logic [15:0]                  occ_o
);

  logic [7:0] ent_src;
  logic [7:0] ent_typ;
  logic       hit;

  // Entry fields from the tables, one byte per entry.
  assign ent_src = cfg_i.src_tab[{ent_i, 3'b000} +: 8];
  assign ent_typ = cfg_i.typ_tab[{ent_i, 3'b000} +: 8];
  assign hit     = (src_i == ent_src) && (typ_i == ent_typ);

  // A hit copies the selected packet bit into the entry's flag.
  always_comb begin
    occ_o = occ_i;
    if (hit) begin
      occ_o[ent_i] = byte_i[bitn_i];
    end
  end

endmodule

### rtl/core/pss_checker.sv
// Port-level checks of the packet snoop signal aspect block and their binding.
module pss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A final byte starts the header reads, so no item is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("item taken straight after a final byte");

  // A byte that is not final leaves the block ready for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> s_axis_tready)
    else $error("block not ready after a byte that is not final");

  // The first aspect follows from the first flag nibble of the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] ==
      pss_pkg::aspect_of(m_axis_tdata[15:12])))
    else $error("aspect of signal one disagrees with its flags");

  // A stalled result holds its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind packet_snoop_signal_aspect pss_checker u_pss_checker (.*);
